// ===== rtl/sfd_pkg.sv =====
// Shared types and constants for the sliding-window frame detector.
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W  = 5;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last_byte;
  } out_item_t;

  // Read-port arbitration between the window tracker and the frame emitter.
  typedef struct packed {
    logic busy;
    logic rd_en;
  } emit_ctl_t;

endpackage

// ===== rtl/sfd_if.sv =====
// Valid/ready channel interfaces for received bytes and frame bytes.
`timescale 1ns / 1ps
interface sfd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [sfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_frame_if;
  logic                       valid;
  logic                       ready;
  logic [sfd_pkg::BYTE_W-1:0] frame_byte;
  logic [sfd_pkg::IDX_W-1:0]  byte_index;
  logic                       last_byte;

  modport source (output valid, output frame_byte, output byte_index, output last_byte,
                  input ready);
  modport sink (input valid, input frame_byte, input byte_index, input last_byte,
                output ready);
endinterface

// ===== rtl/sliding_window_frame_detector.sv =====
// Top level of the sliding-window frame detector.
//
// Channels: rx (sink) takes one received byte per item; frame (source) gives
// frame bytes with byte_index and last_byte. wr_en/wr_data load the header
// byte; write it only while the block is idle.
// Every received byte enters a FRAME_LEN-byte window held in a RAM. A hit is
// an oldest byte equal to the header and a mod-256 sum of the oldest
// FRAME_LEN-1 bytes equal to the newest byte; a running sum decides it in the
// cycle the byte is accepted.
// Throughput: one byte per cycle while no frame is found. After a hit, rx is
// held off while the window is read out of the single RAM read port, oldest
// byte first, through the read address, RAM read data and output queue
// registers; then one byte per cycle while the frame receiver is ready.
// A stalled frame receiver slows the read-out through a two-entry output
// queue; nothing is lost, and rx stays held until all reads are issued.
// Reset: window reads as zeros, write pointer and running sum clear, header
// returns to 0xA5, queue empties.
`timescale 1ns / 1ps
module sliding_window_frame_detector #(
  parameter int FRAME_LEN = 22
) (
  input  logic                       clk,
  input  logic                       rst,
  sfd_rx_if.sink                     rx,
  sfd_frame_if.source                frame,
  input  logic                       wr_en,
  input  logic [sfd_pkg::BYTE_W-1:0] wr_data
);

  localparam int AW = $clog2(FRAME_LEN);

  logic [sfd_pkg::BYTE_W-1:0] header;
  logic                       acc;
  logic                       hit;
  logic [AW-1:0]              base;
  logic [AW-1:0]              rd_addr;
  logic [sfd_pkg::BYTE_W-1:0] rdata;
  sfd_pkg::emit_ctl_t         ctl;

  assign rx.ready = !ctl.busy;
  assign acc      = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= sfd_pkg::HEADER_RESET;
    end else if (wr_en) begin
      header <= wr_data;
    end
  end

  sfd_track #(
    .FRAME_LEN(FRAME_LEN),
    .AW       (AW)
  ) u_track (
    .clk      (clk),
    .rst      (rst),
    .header   (header),
    .acc      (acc),
    .rx_byte  (rx.rx_byte),
    .ctl      (ctl),
    .emit_addr(rd_addr),
    .hit      (hit),
    .base     (base),
    .rdata    (rdata)
  );

  sfd_emit #(
    .FRAME_LEN(FRAME_LEN),
    .AW       (AW)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .hit    (hit),
    .base   (base),
    .rdata  (rdata),
    .ctl    (ctl),
    .rd_addr(rd_addr),
    .frame  (frame)
  );

endmodule

// ===== rtl/sfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sfd_track.sv =====
// Window store, write pointer, running sum and per-item frame check.
`timescale 1ns / 1ps
module sfd_track #(
  parameter int FRAME_LEN = 22,
  parameter int AW        = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sfd_pkg::BYTE_W-1:0] header,
  input  logic                       acc,
  input  logic [sfd_pkg::BYTE_W-1:0] rx_byte,
  input  sfd_pkg::emit_ctl_t         ctl,
  input  logic [AW-1:0]              emit_addr,
  output logic                       hit,
  output logic [AW-1:0]              base,
  output logic [sfd_pkg::BYTE_W-1:0] rdata
);

  localparam logic [AW-1:0] LAST = AW'(FRAME_LEN - 1);

  logic [AW-1:0]              wp;
  logic [AW-1:0]              wp_p1;
  logic [AW-1:0]              wp_p2;
  logic [AW-1:0]              raddr;
  logic [sfd_pkg::BYTE_W-1:0] sum;
  logic [sfd_pkg::BYTE_W-1:0] oldest;
  logic [sfd_pkg::BYTE_W-1:0] second_reg;
  logic [sfd_pkg::BYTE_W-1:0] second;
  logic [sfd_pkg::BYTE_W-1:0] ram_q;
  logic                       pf_pending;
  logic [FRAME_LEN-1:0]       valid;
  logic                       valid_q;

  assign wp_p1 = (wp == LAST) ? '0 : wp + 1'b1;
  assign wp_p2 = (wp_p1 == LAST) ? '0 : wp_p1 + 1'b1;
  assign base  = wp_p1;

  // Prefetch the slot two ahead on each accept; the emitter owns the port while it issues reads.
  assign raddr = ctl.rd_en ? emit_addr : wp_p2;
  assign rdata = valid_q ? ram_q : '0;

  // oldest: slot wp (evicted next). second: slot wp+1 (oldest after the write).
  assign second = pf_pending ? rdata : second_reg;

  // Sum of the oldest FRAME_LEN-1 bytes after the write is sum - evicted.
  assign hit = acc && (second == header) && ((sum - oldest) == rx_byte);

  sfd_ram #(
    .WIDTH(sfd_pkg::BYTE_W),
    .DEPTH(FRAME_LEN)
  ) u_ram (
    .clk  (clk),
    .we   (acc),
    .waddr(wp),
    .wdata(rx_byte),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    valid_q <= valid[raddr];
    if (rst) begin
      wp         <= '0;
      sum        <= '0;
      oldest     <= '0;
      second_reg <= '0;
      pf_pending <= 1'b0;
      valid      <= '0;
    end else begin
      pf_pending <= acc;
      second_reg <= second;
      if (acc) begin
        wp         <= wp_p1;
        sum        <= sum + rx_byte - oldest;
        oldest     <= second;
        valid[wp]  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sfd_emit.sv =====
// Frame read-out sequencer with a two-entry output queue.
`timescale 1ns / 1ps
module sfd_emit #(
  parameter int FRAME_LEN = 22,
  parameter int AW        = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hit,
  input  logic [AW-1:0]              base,
  input  logic [sfd_pkg::BYTE_W-1:0] rdata,
  output sfd_pkg::emit_ctl_t         ctl,
  output logic [AW-1:0]              rd_addr,
  sfd_frame_if.source                frame
);

  localparam logic [AW-1:0] LAST = AW'(FRAME_LEN - 1);

  logic                       busy;
  logic [AW-1:0]              k;
  logic [AW+4:0]              k_ext;
  logic                       inflight;
  logic [sfd_pkg::IDX_W-1:0]  infl_idx;
  logic                       infl_last;
  sfd_pkg::out_item_t         q [2];
  logic                       head;
  logic [1:0]                 count;
  logic                       pop;
  logic                       issue;
  logic [2:0]                 held;

  assign k_ext = {5'b0, k};
  assign pop   = frame.valid && frame.ready;
  // A read issued now passes the RAM read register before it lands in the queue; keep room for it.
  assign held  = {1'b0, count} + {2'b0, inflight};
  assign issue = busy && (held <= ({2'b0, pop} + 3'd1));

  assign ctl.busy  = busy;
  assign ctl.rd_en = issue;

  assign frame.valid      = (count != 2'd0);
  assign frame.frame_byte = q[head].frame_byte;
  assign frame.byte_index = q[head].byte_index;
  assign frame.last_byte  = q[head].last_byte;

  always_ff @(posedge clk) begin
    if (inflight) begin
      q[head ^ count[0]] <= '{frame_byte: rdata, byte_index: infl_idx, last_byte: infl_last};
    end
    if (issue) begin
      infl_idx  <= k_ext[4:0];
      infl_last <= (k == LAST);
    end
    if (rst) begin
      busy     <= 1'b0;
      k        <= '0;
      rd_addr  <= '0;
      inflight <= 1'b0;
      head     <= 1'b0;
      count    <= '0;
    end else begin
      inflight <= issue;
      if (hit) begin
        busy    <= 1'b1;
        k       <= '0;
        rd_addr <= base;
      end else if (issue) begin
        k       <= k + 1'b1;
        rd_addr <= (rd_addr == LAST) ? '0 : rd_addr + 1'b1;
        if (k == LAST) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        head <= ~head;
      end
      count <= count + {1'b0, inflight} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/sfd_checker.sv =====
// Port-level assertions for the frame detector, bound to the top level.
`timescale 1ns / 1ps
module sfd_checker #(
  parameter int FRAME_LEN = 22
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       rx_valid,
  input logic                       rx_ready,
  input logic                       f_valid,
  input logic                       f_ready,
  input logic [sfd_pkg::BYTE_W-1:0] f_byte,
  input logic [sfd_pkg::IDX_W-1:0]  f_idx,
  input logic                       f_last
);

  localparam logic [sfd_pkg::IDX_W-1:0] LAST_IDX = sfd_pkg::IDX_W'((FRAME_LEN - 1) % 32);

  a_reset_empty: assert property (@(posedge clk) rst |=> !f_valid)
    else $error("frame output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_byte) && $stable(f_idx) && $stable(f_last))
    else $error("stalled frame item changed");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_last |-> f_idx == LAST_IDX)
    else $error("last byte flag at wrong index");

  // rx is only held off by a hit, which needs an accepted byte.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(rx_ready) |-> $past(rx_valid && rx_ready))
    else $error("rx ready dropped without an accepted item");

endmodule

bind sliding_window_frame_detector sfd_checker #(
  .FRAME_LEN(FRAME_LEN)
) u_sfd_checker (
  .clk     (clk),
  .rst     (rst),
  .rx_valid(rx.valid),
  .rx_ready(rx.ready),
  .f_valid (frame.valid),
  .f_ready (frame.ready),
  .f_byte  (frame.frame_byte),
  .f_idx   (frame.byte_index),
  .f_last  (frame.last_byte)
);

// ===== tb/sv/tb_sliding_window_frame_detector.sv =====
// Self-checking testbench for the sliding-window frame detector.
`timescale 1ns / 1ps
module tb_sliding_window_frame_detector;

  localparam int FRAME_LEN = 22;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;

  // Keeps its own window copy and the queue of frame bytes still owed.
  class frame_scoreboard;
    logic [sfd_pkg::BYTE_W-1:0] window [FRAME_LEN];
    int unsigned                wpos;
    logic [sfd_pkg::BYTE_W-1:0] header;
    sfd_pkg::out_item_t         owed [$];
    int unsigned                fails;

    function new();
      foreach (window[i]) window[i] = '0;
      wpos   = 0;
      header = sfd_pkg::HEADER_RESET;
      fails  = 0;
    endfunction

    function void set_header(logic [sfd_pkg::BYTE_W-1:0] v);
      header = v;
    endfunction

    function void note_byte(logic [sfd_pkg::BYTE_W-1:0] b);
      int unsigned                oldest;
      logic [sfd_pkg::BYTE_W-1:0] sum;
      sfd_pkg::out_item_t         it;
      window[wpos] = b;
      wpos = (wpos + 1) % FRAME_LEN;
      oldest = wpos;
      if (window[oldest] != header) return;
      sum = '0;
      for (int k = 0; k < FRAME_LEN - 1; k++) sum += window[(oldest + k) % FRAME_LEN];
      if (sum != window[(oldest + FRAME_LEN - 1) % FRAME_LEN]) return;
      for (int k = 0; k < FRAME_LEN; k++) begin
        it.frame_byte = window[(oldest + k) % FRAME_LEN];
        it.byte_index = k[sfd_pkg::IDX_W-1:0];
        it.last_byte  = (k == FRAME_LEN - 1);
        owed.push_back(it);
      end
    endfunction

    function void check_frame(sfd_pkg::out_item_t got);
      sfd_pkg::out_item_t exp;
      if (owed.size() == 0) begin
        $error("unexpected frame item: frame_byte %0h byte_index %0d last_byte %0b",
               got.frame_byte, got.byte_index, got.last_byte);
        fails++;
        return;
      end
      exp = owed.pop_front();
      if (got.frame_byte !== exp.frame_byte) begin
        $error("frame_byte: expected %0h, got %0h", exp.frame_byte, got.frame_byte);
        fails++;
      end
      if (got.byte_index !== exp.byte_index) begin
        $error("byte_index: expected %0d, got %0d", exp.byte_index, got.byte_index);
        fails++;
      end
      if (got.last_byte !== exp.last_byte) begin
        $error("last_byte: expected %0b, got %0b", exp.last_byte, got.last_byte);
        fails++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       wr_en;
  logic [sfd_pkg::BYTE_W-1:0] wr_data;

  sfd_rx_if    rx_ch ();
  sfd_frame_if frame_ch ();

  sliding_window_frame_detector #(
    .FRAME_LEN(FRAME_LEN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .frame(frame_ch),
    .wr_en(wr_en),
    .wr_data(wr_data)
  );

  frame_scoreboard sb = new();

  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame receiver: random stalls, plus one long hold-off on request.
  initial begin
    frame_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        frame_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      frame_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      sfd_pkg::out_item_t got;
      got.frame_byte = frame_ch.frame_byte;
      got.byte_index = frame_ch.byte_index;
      got.last_byte  = frame_ch.last_byte;
      sb.check_frame(got);
    end
  end

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!(rx_ch.valid && rx_ch.ready));
    sb.note_byte(b);
    items_sent++;
    @(negedge clk);
  endtask

  // Header, payload, then the mod-256 sum of everything before it (one bit flipped if broken).
  task automatic send_frame(input logic [sfd_pkg::BYTE_W-1:0] hdr, input bit broken,
                            input bit extreme);
    logic [sfd_pkg::BYTE_W-1:0] fr [FRAME_LEN];
    logic [sfd_pkg::BYTE_W-1:0] sum;
    fr[0] = hdr;
    sum = hdr;
    for (int k = 1; k < FRAME_LEN - 1; k++) begin
      if (extreme) fr[k] = k[0] ? 8'hFF : 8'h00;
      else if ($urandom_range(0, 15) == 0) fr[k] = hdr;
      else fr[k] = 8'($urandom);
      sum += fr[k];
    end
    fr[FRAME_LEN-1] = broken ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum;
    foreach (fr[k]) send_byte(fr[k]);
  endtask

  task automatic send_noise(input logic [sfd_pkg::BYTE_W-1:0] hdr);
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(($urandom_range(0, 3) == 0) ? hdr : 8'($urandom));
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_header(input logic [sfd_pkg::BYTE_W-1:0] v);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(negedge clk);
    wr_en <= 1'b0;
    sb.set_header(v);
  endtask

  // Mostly good frames with random content, some corrupted ones and noise.
  task automatic run_random(input logic [sfd_pkg::BYTE_W-1:0] hdr,
                            input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) send_frame(hdr, 1'b0, 1'b0);
      else if (pick < 8) send_frame(hdr, 1'b1, 1'b0);
      else send_noise(hdr);
    end
  endtask

  initial begin
    rst           = 1'b1;
    wr_en         = 1'b0;
    wr_data       = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero byte under the reset header: no hit, window stays all zeros.
    send_byte(8'h00);
    wait_idle();
    // With header zero the unfilled window completes an all-zero frame.
    write_header(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
    write_header(sfd_pkg::HEADER_RESET);
    send_frame(sfd_pkg::HEADER_RESET, 1'b0, 1'b1);
    wait_idle();

    src_idle_pct = 14;
    snk_idle_pct = 57;
    write_header(8'($urandom_range(1, 254)));
    run_random(sb.header, 55);
    wait_idle();

    src_idle_pct = 57;
    snk_idle_pct = 14;
    write_header(8'hFF);
    run_random(8'hFF, 55);
    wait_idle();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_header(8'h00);
    hold_req = 1'b1;
    run_random(8'h00, 55);
    wait_idle();

    repeat (30) @(negedge clk);
    if (sb.fails == 0 && sb.owed.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
